// ===== src/dq_pkg.sv =====
// Shared types and field widths for the double-ended queue.
package dq_pkg;

    localparam int WORD_W = 32;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Command from the pointer logic to the storage memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage

// ===== src/double_ended_queue.sv =====
// Top level of the double-ended queue: stream handshake, result staging and output register.
// A result passes through the staging register and then the output register to m_tvalid.
// A new operation is not taken while a result is staged or the output waits on m_tready.
// Reset (aresetn low, synchronous) empties the queue and the result path; storage is not cleared.
// The memory contents are read only at entries that were written since reset.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dq_pkg::WORD_W-1:0]    s_tdata,   // [31:0] value
    input  logic [dq_pkg::FUNC_W-1:0]    s_tuser,   // [1:0] func
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dq_pkg::WORD_W-1:0]    m_tdata,   // [31:0] value_out
    output logic [dq_pkg::STAT_W-1:0]    m_tuser    // [1:0] status
);
    import dq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic          accept;
    status_t       status;
    mem_cmd_t      cmd;
    logic [AW-1:0] waddr, raddr;
    logic [CW-1:0] count;
    logic [WORD_W-1:0] rdata;

    logic          p1_valid_reg;
    status_t       p1_status_reg;
    logic          p1_pop_reg;
    logic          m_valid_reg;
    logic [WORD_W-1:0] m_data_reg;
    status_t       m_status_reg;

    // A new operation waits until no result is staged and the output register is free.
    assign s_tready = !p1_valid_reg && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .func    (func_t'(s_tuser)),
        .status  (status),
        .cmd     (cmd),
        .waddr   (waddr),
        .raddr   (raddr),
        .count   (count)
    );

    dq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .cmd   (cmd),
        .waddr (waddr),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
        end
        if (accept) begin
            p1_status_reg <= status;
            p1_pop_reg    <= cmd.rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_valid_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (p1_valid_reg) begin
            m_status_reg <= p1_status_reg;
            m_data_reg   <= p1_pop_reg ? rdata : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(DEPTH))
        else $error("entry count exceeds the queue depth");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_OK) |-> m_tdata == '0)
        else $error("refused operation returned a non-zero word");

    a_no_rd_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_en && cmd.rd_en))
        else $error("memory read and write issued together");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> p1_valid_reg && !s_tready ##1 m_tvalid)
        else $error("transferred operation did not reach the output register");

endmodule

// ===== src/dq_mem.sv =====
// Storage memory of the queue: one write port and one registered read port.
module dq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                         aclk,
    input  dq_pkg::mem_cmd_t             cmd,
    input  logic [AW-1:0]                waddr,
    input  logic [dq_pkg::WORD_W-1:0]    wdata,
    input  logic [AW-1:0]                raddr,
    output logic [dq_pkg::WORD_W-1:0]    rdata
);
    import dq_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dq_ctrl.sv =====
// Head pointer and entry count of the ring, with the address and status decision per operation.
module dq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  dq_pkg::func_t                func,
    output dq_pkg::status_t              status,
    output dq_pkg::mem_cmd_t             cmd,
    output logic [AW-1:0]                waddr,
    output logic [AW-1:0]                raddr,
    output logic [CW-1:0]                count
);
    import dq_pkg::*;

    localparam int SW = AW + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;

    logic          full, empty;
    logic [AW-1:0] head_dec, head_inc, tail, last;
    logic [SW-1:0] sum;

    always_comb begin
        full     = (count_reg == CW'(DEPTH));
        empty    = (count_reg == '0);
        head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
        head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        // The sum stays below twice the depth, so one subtraction wraps it.
        sum      = SW'(head_reg) + SW'(count_reg);
        tail     = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
        last     = (tail == '0) ? AW'(DEPTH - 1) : tail - AW'(1);
    end

    always_comb begin
        status     = STATUS_OK;
        cmd        = '0;
        waddr      = head_dec;
        raddr      = head_reg;
        head_next  = head_reg;
        count_next = count_reg;
        case (func)
            FUNC_PUSH_FRONT: begin
                if (full) begin
                    status = STATUS_FULL;
                end else begin
                    cmd.wr_en  = accept;
                    waddr      = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_PUSH_REAR: begin
                if (full) begin
                    status = STATUS_FULL;
                end else begin
                    cmd.wr_en  = accept;
                    waddr      = tail;
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_POP_FRONT: begin
                if (empty) begin
                    status = STATUS_EMPTY;
                end else begin
                    cmd.rd_en  = accept;
                    raddr      = head_reg;
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            FUNC_POP_REAR: begin
                if (empty) begin
                    status = STATUS_EMPTY;
                end else begin
                    cmd.rd_en  = accept;
                    raddr      = last;
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (accept) begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the double-ended queue with a ring-buffer predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int RANDOM_OPS = 1320;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_AFTER = 400;
    localparam int HOLD_LEN   = 250;

    typedef struct packed {
        func_t              op;
        logic [WORD_W-1:0]  word;
    } dq_op_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        status_t            status;
    } dq_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata  = '0;   // [31:0] value
    logic [FUNC_W-1:0]   s_tuser  = '0;   // [1:0] func
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [WORD_W-1:0]   m_tdata;         // [31:0] value_out
    logic [STAT_W-1:0]   m_tuser;         // [1:0] status

    double_ended_queue #(.DEPTH(DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: the ring of stored words, the front position and the fill level.
    logic [WORD_W-1:0]  ring_words [DEPTH];
    logic [3:0]         ring_head  = '0;
    logic [4:0]         ring_fill  = '0;

    dq_op_t      pending_ops[$];
    dq_result_t  expected_results[$];
    int unsigned ops_total    = 0;
    int unsigned ops_accepted = 0;
    int unsigned err_count    = 0;
    int unsigned cycle_count  = 0;
    bit          op_taken     = 1'b0;
    bit          rx_hold      = 1'b0;
    bit          tx_burst     = 1'b0;
    bit          rx_burst     = 1'b0;

    function automatic dq_result_t apply_deque_op(dq_op_t item);
        dq_result_t res;
        logic [3:0] pos;
        res.word   = '0;
        res.status = STATUS_OK;
        case (item.op)
            FUNC_PUSH_FRONT: begin
                if (ring_fill == DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    ring_head = ring_head - 4'd1;
                    ring_words[ring_head] = item.word;
                    ring_fill = ring_fill + 5'd1;
                end
            end
            FUNC_PUSH_REAR: begin
                if (ring_fill == DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    pos = ring_head + ring_fill[3:0];
                    ring_words[pos] = item.word;
                    ring_fill = ring_fill + 5'd1;
                end
            end
            FUNC_POP_FRONT: begin
                if (ring_fill == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.word  = ring_words[ring_head];
                    ring_head = ring_head + 4'd1;
                    ring_fill = ring_fill - 5'd1;
                end
            end
            default: begin
                if (ring_fill == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    pos = ring_head + ring_fill[3:0] - 4'd1;
                    res.word  = ring_words[pos];
                    ring_fill = ring_fill - 5'd1;
                end
            end
        endcase
        return res;
    endfunction

    // Mostly short gaps, now and then a long one; none at all while a burst is running.
    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    task automatic queue_op(func_t op, logic [WORD_W-1:0] word);
        dq_op_t item;
        item.op   = op;
        item.word = word;
        pending_ops.push_back(item);
        ops_total++;
    endtask

    // Sample both channels at the rising edge: predict on input transfers, check output ones.
    always @(posedge aclk) begin : sample_proc
        dq_op_t     item;
        dq_result_t got;
        dq_result_t want;
        cycle_count++;
        if (aresetn && s_tvalid && s_tready) begin
            item.op   = func_t'(s_tuser);
            item.word = s_tdata;
            expected_results.push_back(apply_deque_op(item));
            ops_accepted++;
            op_taken = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.word   = m_tdata;
            got.status = status_t'(m_tuser);
            if (expected_results.size() == 0) begin
                $error("result transfer with no expectation waiting: value_out %0d status %0d",
                       $signed(got.word), got.status);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.word !== want.word) begin
                    $error("value_out: expected %0d, actual %0d",
                           $signed(want.word), $signed(got.word));
                    err_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("[double_ended_queue] ERROR");
            $finish;
        end
    end

    // Input driver: a new transfer is offered only once the previous one has gone through.
    always @(negedge aclk) begin : drive_proc
        int unsigned gap_left;
        bit          free;
        dq_op_t      item;
        if (aresetn) begin
            free = !s_tvalid || op_taken;
            op_taken = 1'b0;
            if (!free) begin
                s_tvalid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                item = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= item.op;
                s_tdata  <= item.word;
                if ($urandom_range(0, 49) == 0) begin
                    tx_burst = !tx_burst;
                end
                gap_left = pick_gap(tx_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : ready_proc
        int unsigned stall_left;
        if (aresetn) begin
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 49) == 0) begin
                    rx_burst = !rx_burst;
                end
                if ($urandom_range(0, 99) < 30) begin
                    stall_left = pick_gap(rx_burst);
                end
            end
        end
    end

    // Long hold-off on the result side while the sender keeps offering operations.
    initial begin
        while (ops_accepted < HOLD_AFTER) begin
            @(posedge aclk);
        end
        rx_hold = 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        rx_hold = 1'b0;
    end

    initial begin : stimulus_proc
        int unsigned push_pct;
        int unsigned r;
        func_t       op;
        logic [WORD_W-1:0] word;

        // Directed part: pops on an empty queue, extreme words, wrap of the front, full queue.
        queue_op(FUNC_POP_FRONT, 32'h1234_5678);
        queue_op(FUNC_POP_REAR, 32'hFFFF_FFFF);
        queue_op(FUNC_PUSH_FRONT, 32'h7FFF_FFFF);
        queue_op(FUNC_PUSH_REAR, 32'h8000_0000);
        queue_op(FUNC_POP_REAR, 32'h0);
        queue_op(FUNC_POP_FRONT, 32'h0);
        for (int k = 0; k < DEPTH; k++) begin
            word = (k == 3) ? 32'hFFFF_FFFF : (k == 7) ? 32'h0 : $urandom;
            queue_op(k[0] ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT, word);
        end
        queue_op(FUNC_PUSH_REAR, 32'hDEAD_BEEF);
        queue_op(FUNC_PUSH_FRONT, 32'h8000_0000);
        queue_op(FUNC_POP_FRONT, 32'h0);
        queue_op(FUNC_POP_REAR, 32'h0);

        // Random part: stretches that lean towards pushes, towards pops or neither, so full and empty recur.
        push_pct = 50;
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                op = $urandom_range(0, 1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT;
            end else begin
                op = $urandom_range(0, 1) ? FUNC_POP_REAR : FUNC_POP_FRONT;
            end
            case ($urandom_range(0, 9))
                0:       word = 32'h8000_0000;
                1:       word = 32'h7FFF_FFFF;
                2:       word = 32'h0;
                3:       word = 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            queue_op(op, word);
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (ops_accepted < ops_total) begin
            @(posedge aclk);
        end
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        if (err_count == 0) begin
            $display("[double_ended_queue] OK");
        end else begin
            $display("[double_ended_queue] ERROR");
        end
        $finish;
    end

endmodule
